### rtl/ocx_pkg.sv
// Shared types, codes and helpers for the order crossover block.
// Depends on nothing; ocx_front, ocx_back and the top level use it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package ocx_pkg;

   localparam int MAX_CITIES_DEFAULT = 64;
   localparam int FIELD_LIMIT        = 64;
   localparam int CITY_W             = 6;
   localparam int POS_W              = 6;
   localparam int COUNT_W            = 7;
   localparam int USED_W             = 64;
   localparam int QUEUE_DEPTH        = 2;
   localparam int CSR_ADDR_W         = 3;
   localparam int CSR_DATA_W         = 32;

   localparam logic [COUNT_W-1:0] CITY_COUNT_RESET = 7'd20;

   // register index decoded from csr_paddr[2]
   localparam logic REG_CITY_COUNT = 1'b0;

   // input command codes
   localparam logic [1:0] CMD_LOAD_FIRST  = 2'd0;
   localparam logic [1:0] CMD_LOAD_SECOND = 2'd1;
   localparam logic [1:0] CMD_CROSS       = 2'd2;

   // queued work kinds
   localparam logic [1:0] KIND_LOAD_FIRST  = 2'd0;
   localparam logic [1:0] KIND_LOAD_SECOND = 2'd1;
   localparam logic [1:0] KIND_CROSS       = 2'd2;

   typedef struct packed {
      logic [1:0]        command;
      logic [POS_W-1:0]  position;
      logic [CITY_W-1:0] city;
      logic [POS_W-1:0]  cut_first;
      logic [POS_W-1:0]  cut_second;
   } req_payload_type;

   typedef struct packed {
      logic [POS_W-1:0]  gene_position;
      logic [CITY_W-1:0] gene_city;
      logic              last_gene;
      logic              exhausted;
   } rsp_payload_type;

   // loads: a = position, b = city; crossover: a = low cut, b = high cut
   typedef struct packed {
      logic [1:0]       kind;
      logic [POS_W-1:0] a;
      logic [POS_W-1:0] b;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } work_type;

   // Clamp the configured tour length to 1..depth.
   function automatic logic [COUNT_W-1:0] tour_length(input logic [COUNT_W-1:0] count,
                                                      input logic [COUNT_W-1:0] depth);
      logic [COUNT_W-1:0] n;
      n = count;
      if (n < 7'd1) begin
         n = 7'd1;
      end
      if (n > depth) begin
         n = depth;
      end
      return n;
   endfunction

endpackage

`default_nettype wire

### rtl/ocx_stream_if.sv
// Valid/ready stream channel carrying one payload item per handshake.
// Depends on nothing; the payload type is given at instantiation.
`timescale 1ns / 1ps
`default_nettype none

interface ocx_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/ocx_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module ocx_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/ocx_front.sv
// Front end: accept items, classify them and hold them in a short queue.
// Depends on ocx_pkg and ocx_stream_if.
`timescale 1ns / 1ps
`default_nettype none

module ocx_front #(
   parameter int MAX_CITIES = ocx_pkg::MAX_CITIES_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   ocx_stream_if.sink                         req,
   input  wire logic [ocx_pkg::COUNT_W-1:0]   city_count,
   output ocx_pkg::work_type                  work,
   input  wire logic                          pop
);

   localparam int DEPTH = (MAX_CITIES < ocx_pkg::FIELD_LIMIT) ? MAX_CITIES
                                                              : ocx_pkg::FIELD_LIMIT;
   localparam logic [ocx_pkg::COUNT_W-1:0] DEPTH_C = ocx_pkg::COUNT_W'(DEPTH);
   localparam int QPTR_W = $clog2(ocx_pkg::QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(ocx_pkg::QUEUE_DEPTH + 1);
   localparam logic [QCNT_W-1:0] QFULL = QCNT_W'(ocx_pkg::QUEUE_DEPTH);

   ocx_pkg::entry_type entry;
   logic               keep;
   logic [ocx_pkg::COUNT_W-1:0] n;
   logic [ocx_pkg::POS_W-1:0]   lo;
   logic [ocx_pkg::POS_W-1:0]   hi;
   logic [ocx_pkg::POS_W-1:0]   last_pos;

   ocx_pkg::entry_type queue_ff [ocx_pkg::QUEUE_DEPTH];
   logic [QPTR_W-1:0]  head_ff, head_in;
   logic [QPTR_W-1:0]  tail_ff, tail_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               push;
   logic               do_pop;

   // Order and saturate the cuts; drop unknown commands and out-of-store loads.
   always_comb begin
      n        = ocx_pkg::tour_length(city_count, DEPTH_C);
      last_pos = ocx_pkg::POS_W'(n - 7'd1);
      lo       = req.payload.cut_first;
      hi       = req.payload.cut_second;
      if (lo > hi) begin
         lo = req.payload.cut_second;
         hi = req.payload.cut_first;
      end
      if (lo > last_pos) begin
         lo = last_pos;
      end
      if (hi > last_pos) begin
         hi = last_pos;
      end
      entry.kind = ocx_pkg::KIND_CROSS;
      entry.a    = req.payload.position;
      entry.b    = req.payload.city;
      keep       = 1'b0;
      unique case (req.payload.command)
         ocx_pkg::CMD_LOAD_FIRST: begin
            entry.kind = ocx_pkg::KIND_LOAD_FIRST;
            keep       = {1'b0, req.payload.position} < DEPTH_C;
         end
         ocx_pkg::CMD_LOAD_SECOND: begin
            entry.kind = ocx_pkg::KIND_LOAD_SECOND;
            keep       = {1'b0, req.payload.position} < DEPTH_C;
         end
         ocx_pkg::CMD_CROSS: begin
            entry.kind = ocx_pkg::KIND_CROSS;
            entry.a    = lo;
            entry.b    = hi;
            keep       = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req.ready  = count_ff != QFULL;
   assign push       = req.valid && req.ready && keep;
   assign work.valid = count_ff != '0;
   assign work.entry = queue_ff[head_ff];
   assign do_pop     = pop && work.valid;

   always_comb begin
      head_in  = do_pop ? head_ff + 1'b1 : head_ff;
      tail_in  = push ? tail_ff + 1'b1 : tail_ff;
      count_in = count_ff + QCNT_W'(push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
      if (push) begin
         queue_ff[tail_ff] <= entry;
      end
   end

endmodule

`default_nettype wire

### rtl/ocx_back.sv
// Back end: carry out loads into the parent stores and run the crossover walk.
// Depends on ocx_pkg, ocx_stream_if and ocx_ram.
`timescale 1ns / 1ps
`default_nettype none

module ocx_back #(
   parameter int MAX_CITIES = ocx_pkg::MAX_CITIES_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [ocx_pkg::COUNT_W-1:0]   city_count,
   input  wire ocx_pkg::work_type             work,
   output logic                               pop,
   ocx_stream_if.source                       rsp
);

   localparam int DEPTH = (MAX_CITIES < ocx_pkg::FIELD_LIMIT) ? MAX_CITIES
                                                              : ocx_pkg::FIELD_LIMIT;
   localparam logic [ocx_pkg::COUNT_W-1:0] DEPTH_C = ocx_pkg::COUNT_W'(DEPTH);
   localparam int AW = $clog2(DEPTH);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MARK = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]                    state_ff, state_in;
   logic [ocx_pkg::COUNT_W-1:0]   p_ff, p_in;
   logic [ocx_pkg::COUNT_W-1:0]   scan_ff, scan_in;
   logic [ocx_pkg::COUNT_W-1:0]   n_ff, n_in;
   logic [ocx_pkg::POS_W-1:0]     lo_ff, lo_in;
   logic [ocx_pkg::POS_W-1:0]     hi_ff, hi_in;
   logic [ocx_pkg::USED_W-1:0]    used_ff, used_in;

   logic                          rsp_valid_ff;
   ocx_pkg::rsp_payload_type      rsp_data_ff;

   logic                          fp_we, sp_we;
   logic [ocx_pkg::CITY_W-1:0]    fp_rdata, sp_rdata;
   logic                          out_free;
   logic                          emit;
   logic                          in_seg;
   logic                          last;
   logic [ocx_pkg::CITY_W-1:0]    gene;
   logic                          fail;

   // Read addresses follow the next position and scan pointer, so the data
   // seen in a cycle belongs to the registered position and pointer.
   ocx_ram #(.WIDTH(ocx_pkg::CITY_W), .DEPTH(DEPTH)) u_first (
      .clock   (clock),
      .wr_en   (fp_we),
      .wr_addr (work.entry.a[AW-1:0]),
      .wr_data (work.entry.b),
      .rd_addr (p_in[AW-1:0]),
      .rd_data (fp_rdata)
   );

   ocx_ram #(.WIDTH(ocx_pkg::CITY_W), .DEPTH(DEPTH)) u_second (
      .clock   (clock),
      .wr_en   (sp_we),
      .wr_addr (work.entry.a[AW-1:0]),
      .wr_data (work.entry.b),
      .rd_addr (scan_in[AW-1:0]),
      .rd_data (sp_rdata)
   );

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign in_seg   = (p_ff >= {1'b0, lo_ff}) && (p_ff <= {1'b0, hi_ff});
   assign last     = p_ff == (n_ff - 7'd1);

   always_comb begin
      state_in = state_ff;
      p_in     = p_ff;
      scan_in  = scan_ff;
      n_in     = n_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      used_in  = used_ff;
      pop      = 1'b0;
      fp_we    = 1'b0;
      sp_we    = 1'b0;
      emit     = 1'b0;
      gene     = '0;
      fail     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (work.valid) begin
               pop = 1'b1;
               unique case (work.entry.kind)
                  ocx_pkg::KIND_LOAD_FIRST:  fp_we = 1'b1;
                  ocx_pkg::KIND_LOAD_SECOND: sp_we = 1'b1;
                  ocx_pkg::KIND_CROSS: begin
                     lo_in    = work.entry.a;
                     hi_in    = work.entry.b;
                     n_in     = ocx_pkg::tour_length(city_count, DEPTH_C);
                     used_in  = '0;
                     scan_in  = '0;
                     p_in     = {1'b0, work.entry.a};
                     state_in = ST_MARK;
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         ST_MARK: begin
            used_in = used_ff | (ocx_pkg::USED_W'(1) << fp_rdata);
            if (p_ff[ocx_pkg::POS_W-1:0] == hi_ff) begin
               p_in     = '0;
               state_in = ST_EMIT;
            end else begin
               p_in = p_ff + 7'd1;
            end
         end
         ST_EMIT: begin
            priority if (in_seg) begin
               emit = out_free;
               gene = fp_rdata;
            end else if (scan_ff >= n_ff) begin
               emit = out_free;
               fail = 1'b1;
            end else if (used_ff[sp_rdata]) begin
               scan_in = scan_ff + 7'd1;
            end else begin
               emit = out_free;
               gene = sp_rdata;
               if (out_free) begin
                  used_in = used_ff | (ocx_pkg::USED_W'(1) << sp_rdata);
                  scan_in = scan_ff + 7'd1;
               end
            end
            if (emit) begin
               if (last) begin
                  state_in = ST_IDLE;
               end else begin
                  p_in = p_ff + 7'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         p_ff         <= '0;
         scan_ff      <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         p_ff     <= p_in;
         scan_ff  <= scan_in;
         used_ff  <= used_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      n_ff  <= n_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      if (emit) begin
         rsp_data_ff.gene_position <= p_ff[ocx_pkg::POS_W-1:0];
         rsp_data_ff.gene_city     <= gene;
         rsp_data_ff.last_gene     <= last;
         rsp_data_ff.exhausted     <= fail;
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;

   a_last_ends_walk: assert property (@(posedge clock) disable iff (reset)
      emit && last |=> state_ff == ST_IDLE)
      else $error("walk did not end after last gene");

   a_scan_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> scan_ff <= n_ff && p_ff < n_ff)
      else $error("scan pointer or position beyond tour");

   a_mark_in_segment: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MARK |-> p_ff[ocx_pkg::POS_W-1:0] >= lo_ff
                              && p_ff[ocx_pkg::POS_W-1:0] <= hi_ff)
      else $error("mark pass left the segment");

   a_exhausted_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.exhausted |-> rsp_data_ff.gene_city == '0)
      else $error("exhausted gene carries a city");

   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !pop && !fp_we && !sp_we)
      else $error("queue popped during crossover");

endmodule

`default_nettype wire

### rtl/order_crossover_permutation.sv
// Top level of the order crossover block: register port, front end, back end.
// Depends on ocx_pkg, ocx_stream_if, ocx_front, ocx_back (and ocx_ram below).
//
//   channel   direction   handshake                   carries
//   req       in          req.valid / req.ready       command, position, city, cuts
//   rsp       out         rsp.valid / rsp.ready       one offspring gene per item
//   csr       in/out      psel, penable, pwrite       city_count at byte address 0
//
// A load is written into its parent store from the idle state. A crossover leaves the
// queue, marks the parent-one cities of the segment, then emits one gene per position,
// skipping parent-two cities already used; each parent store has a single read port.
// The front queue (two items) keeps accepting until full while the back end walks.
// A stalled rsp holds the walk; the next gene waits in the state registers.
// Reset is synchronous and clears control state and city_count to 20.
`timescale 1ns / 1ps
`default_nettype none

module order_crossover_permutation #(
   parameter int MAX_CITIES = ocx_pkg::MAX_CITIES_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   ocx_stream_if.sink                             req,
   ocx_stream_if.source                           rsp,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [ocx_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [ocx_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic      [ocx_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                   csr_pready
);

   logic [ocx_pkg::COUNT_W-1:0] city_count_ff, city_count_in;
   logic                        csr_write;
   ocx_pkg::work_type           work;
   logic                        pop;

   // Register file: one register, decoded by word index only.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      city_count_in = city_count_ff;
      if (csr_write && csr_paddr[2] == ocx_pkg::REG_CITY_COUNT) begin
         city_count_in = csr_pwdata[ocx_pkg::COUNT_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == ocx_pkg::REG_CITY_COUNT) begin
         csr_prdata = ocx_pkg::CSR_DATA_W'(city_count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         city_count_ff <= ocx_pkg::CITY_COUNT_RESET;
      end else begin
         city_count_ff <= city_count_in;
      end
   end

   // Classify and queue incoming items.
   ocx_front #(.MAX_CITIES(MAX_CITIES)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .city_count (city_count_ff),
      .work       (work),
      .pop        (pop)
   );

   // Execute loads and crossover walks, drive results.
   ocx_back #(.MAX_CITIES(MAX_CITIES)) u_back (
      .clock      (clock),
      .reset      (reset),
      .city_count (city_count_ff),
      .work       (work),
      .pop        (pop),
      .rsp        (rsp)
   );

endmodule

`default_nettype wire
